// ----- src/sglcd_pkg.sv -----
// Shared types and constants of the serial graphic LCD controller.
// No dependencies; every other file takes names from here by scope.
package sglcd_pkg;

  // Field widths of the sample and result beats
  localparam int COL_W  = 7;
  localparam int BANK_W = 3;
  localparam int BYTE_W = 8;

  // Default display geometry
  localparam int DEF_COLUMNS = 84;
  localparam int DEF_BANKS   = 6;

  // Command decode patterns
  localparam logic [BYTE_W-1:0] CMD_FUNC_MASK = 8'hF8;
  localparam logic [BYTE_W-1:0] CMD_FUNC      = 8'h20;
  localparam logic [BYTE_W-1:0] CMD_DISP_MASK = 8'hFA;
  localparam logic [BYTE_W-1:0] CMD_DISP      = 8'h08;
  localparam logic [BYTE_W-1:0] CMD_SETY_MASK = 8'hF8;
  localparam logic [BYTE_W-1:0] CMD_SETY      = 8'h40;
  localparam logic [BYTE_W-1:0] CMD_SETX_MASK = 8'h80;
  localparam logic [BYTE_W-1:0] CMD_SETX      = 8'h80;

  localparam logic [2:0] LAST_BIT = 3'd7;

  // One sample of the serial pins plus the view address
  typedef struct packed {
    logic              rst_n;
    logic              cs_n;
    logic              dc;
    logic              sdin;
    logic              sclk;
    logic [COL_W-1:0]  view_column;
    logic [BANK_W-1:0] view_bank;
  } item_t;

  // Write event and mode flags produced by the decode stage
  typedef struct packed {
    logic              wr;
    logic [COL_W-1:0]  wcol;
    logic [BANK_W-1:0] wbank;
    logic [BYTE_W-1:0] wbyte;
    logic              pd;
    logic              vert;
    logic              ext;
    logic              disp_d;
    logic              disp_e;
  } res_t;

endpackage

// ----- src/sglcd_if.sv -----
// Valid/ready channel interfaces for the sample and result beats.
// Depends on sglcd_pkg for field widths.
interface sglcd_in_if;
  logic                          valid;
  logic                          ready;
  logic                          rst_n;
  logic                          cs_n;
  logic                          dc;
  logic                          sdin;
  logic                          sclk;
  logic [sglcd_pkg::COL_W-1:0]   view_column;
  logic [sglcd_pkg::BANK_W-1:0]  view_bank;

  modport source (output valid, rst_n, cs_n, dc, sdin, sclk, view_column, view_bank,
                  input ready);
  modport sink   (input valid, rst_n, cs_n, dc, sdin, sclk, view_column, view_bank,
                  output ready);
endinterface

interface sglcd_out_if;
  logic                          valid;
  logic                          ready;
  logic                          ram_write;
  logic [sglcd_pkg::COL_W-1:0]   write_column;
  logic [sglcd_pkg::BANK_W-1:0]  write_bank;
  logic [sglcd_pkg::BYTE_W-1:0]  write_byte;
  logic [sglcd_pkg::BYTE_W-1:0]  view_data;
  logic                          power_down;
  logic                          vertical_addressing;
  logic                          extended_set;
  logic                          display_d;
  logic                          display_e;

  modport source (output valid, ram_write, write_column, write_bank, write_byte, view_data,
                  power_down, vertical_addressing, extended_set, display_d, display_e,
                  input ready);
  modport sink   (input valid, ram_write, write_column, write_bank, write_byte, view_data,
                  power_down, vertical_addressing, extended_set, display_d, display_e,
                  output ready);
endinterface

// ----- src/sglcd_ram.sv -----
// Display RAM: one write port, one registered read port, clearing pass after reset.
// Depends on sglcd_pkg for the byte width.
module sglcd_ram #(
  parameter int DEPTH  = sglcd_pkg::DEF_COLUMNS * sglcd_pkg::DEF_BANKS,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [ADDR_W-1:0]            wr_addr,
  input  logic [sglcd_pkg::BYTE_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [ADDR_W-1:0]            rd_addr,
  output logic [sglcd_pkg::BYTE_W-1:0] rd_data,
  output logic                         busy
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W:0]   DEPTH_LIM = (ADDR_W+1)'(DEPTH);

  logic [sglcd_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [sglcd_pkg::BYTE_W-1:0] rd_data_r;
  logic                         clr_busy_r;
  logic [ADDR_W-1:0]            clr_addr_r;

  // Sweep the array to zero after reset, one entry per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == LAST_ADDR) begin
        clr_busy_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // Write port, shared with the clearing pass
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; hold the data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if ({1'b0, rd_addr} < DEPTH_LIM) begin
        rd_data_r <= mem[rd_addr];
      end else begin
        rd_data_r <= '0;
      end
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_busy_r;

endmodule

// ----- src/sglcd_core.sv -----
// Serial shift, command decode and address pointer of the controller.
// Depends on sglcd_pkg for the item and result types and command codes.
module sglcd_core #(
  parameter int COLUMNS = sglcd_pkg::DEF_COLUMNS,
  parameter int BANKS   = sglcd_pkg::DEF_BANKS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  sglcd_pkg::item_t     item,
  output sglcd_pkg::res_t      res
);

  localparam int CW = sglcd_pkg::COL_W;
  localparam int BW = sglcd_pkg::BANK_W;
  localparam logic [CW:0] COL_LIM  = (CW+1)'(COLUMNS);
  localparam logic [BW:0] BANK_LIM = (BW+1)'(BANKS);

  logic [7:0]    sb_r, sb_nxt;
  logic [2:0]    bc_r, bc_nxt;
  logic          cwh_r, cwh_nxt;
  logic          ds_r, ds_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [BW-1:0] bank_r, bank_nxt;
  logic          vert_r, vert_nxt;
  logic          ext_r, ext_nxt;
  logic          pd_r, pd_nxt;
  logic          dd_r, dd_nxt;
  logic          de_r, de_nxt;

  logic [7:0]    byte_in;
  logic [CW:0]   col_inc;
  logic [BW:0]   bank_inc;
  logic [CW:0]   adv_col;
  logic [BW:0]   adv_bank;

  assign byte_in  = {sb_r[7:1], item.sdin};
  assign col_inc  = {1'b0, col_r} + 1'b1;
  assign bank_inc = {1'b0, bank_r} + 1'b1;

  // Next pointer after a data byte, wrapping in the current direction
  always_comb begin
    adv_col  = {1'b0, col_r};
    adv_bank = {1'b0, bank_r};
    if (vert_r) begin
      adv_bank = bank_inc;
      if (bank_inc >= BANK_LIM) begin
        adv_bank = '0;
        adv_col  = col_inc;
      end
      if (adv_col >= COL_LIM) begin
        adv_col = '0;
      end
    end else begin
      adv_col = col_inc;
      if (col_inc >= COL_LIM) begin
        adv_col  = '0;
        adv_bank = bank_inc;
      end
      if (adv_bank >= BANK_LIM) begin
        adv_bank = '0;
      end
    end
  end

  // Sample step: reset pin, deselect, clock edge, byte action
  always_comb begin
    sb_nxt   = sb_r;
    bc_nxt   = bc_r;
    cwh_nxt  = cwh_r;
    ds_nxt   = ds_r;
    col_nxt  = col_r;
    bank_nxt = bank_r;
    vert_nxt = vert_r;
    ext_nxt  = ext_r;
    pd_nxt   = pd_r;
    dd_nxt   = dd_r;
    de_nxt   = de_r;
    res.wr    = 1'b0;
    res.wcol  = '0;
    res.wbank = '0;
    res.wbyte = '0;
    if (!item.rst_n) begin
      sb_nxt   = '0;
      bc_nxt   = '0;
      cwh_nxt  = 1'b0;
      ds_nxt   = 1'b0;
      col_nxt  = '0;
      bank_nxt = '0;
      vert_nxt = 1'b0;
      ext_nxt  = 1'b0;
      pd_nxt   = 1'b1;
      dd_nxt   = 1'b0;
      de_nxt   = 1'b0;
    end else if (item.cs_n) begin
      sb_nxt = '0;
      bc_nxt = '0;
    end else begin
      ds_nxt = item.dc;
      if (!item.sclk) begin
        cwh_nxt = 1'b0;
      end else if (!cwh_r) begin
        cwh_nxt = 1'b1;
        if (bc_r == sglcd_pkg::LAST_BIT) begin
          sb_nxt = byte_in;
          bc_nxt = '0;
          if (item.dc) begin
            if ({1'b0, col_r} < COL_LIM && {1'b0, bank_r} < BANK_LIM) begin
              res.wr    = 1'b1;
              res.wcol  = col_r;
              res.wbank = bank_r;
              res.wbyte = byte_in;
            end
            col_nxt  = adv_col[CW-1:0];
            bank_nxt = adv_bank[BW-1:0];
          end else if ((byte_in & sglcd_pkg::CMD_FUNC_MASK) == sglcd_pkg::CMD_FUNC) begin
            ext_nxt  = byte_in[0];
            vert_nxt = byte_in[1];
            pd_nxt   = byte_in[2];
          end else if (!ext_r) begin
            if ((byte_in & sglcd_pkg::CMD_DISP_MASK) == sglcd_pkg::CMD_DISP) begin
              dd_nxt = byte_in[2];
              de_nxt = byte_in[0];
            end else if ((byte_in & sglcd_pkg::CMD_SETY_MASK) == sglcd_pkg::CMD_SETY) begin
              if ({1'b0, byte_in[2:0]} < BANK_LIM) begin
                bank_nxt = byte_in[2:0];
              end
            end else if ((byte_in & sglcd_pkg::CMD_SETX_MASK) == sglcd_pkg::CMD_SETX) begin
              if ({1'b0, byte_in[6:0]} < COL_LIM) begin
                col_nxt = byte_in[6:0];
              end
            end
          end
        end else begin
          sb_nxt = {byte_in[6:0], 1'b0};
          bc_nxt = bc_r + 1'b1;
        end
      end
    end
    res.pd     = pd_nxt;
    res.vert   = vert_nxt;
    res.ext    = ext_nxt;
    res.disp_d = dd_nxt;
    res.disp_e = de_nxt;
  end

  // Advance the controller state once per sample beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_r   <= '0;
      bc_r   <= '0;
      cwh_r  <= 1'b0;
      ds_r   <= 1'b0;
      col_r  <= '0;
      bank_r <= '0;
      vert_r <= 1'b0;
      ext_r  <= 1'b0;
      pd_r   <= 1'b1;
      dd_r   <= 1'b0;
      de_r   <= 1'b0;
    end else if (fire) begin
      sb_r   <= sb_nxt;
      bc_r   <= bc_nxt;
      cwh_r  <= cwh_nxt;
      ds_r   <= ds_nxt;
      col_r  <= col_nxt;
      bank_r <= bank_nxt;
      vert_r <= vert_nxt;
      ext_r  <= ext_nxt;
      pd_r   <= pd_nxt;
      dd_r   <= dd_nxt;
      de_r   <= de_nxt;
    end
  end

endmodule

// ----- src/serial_graphic_lcd_controller.sv -----
// Top level of the serial graphic LCD controller: input register, decode, output register.
// Depends on sglcd_pkg, sglcd_in_if/sglcd_out_if, sglcd_core and sglcd_ram.
//
// Usage:
//   in_bus carries one sample beat per ready cycle: the serial pin levels (rst_n, cs_n, dc,
//   sdin, sclk) and a view address (view_column, view_bank) into the display RAM.
//   out_bus returns exactly one result beat per sample: the RAM write this sample
//   caused (if any), the RAM byte at the view address after that write, and the
//   current mode flags.
//   A beat accepted on in_bus is held and decoded in the input register, and its result
//   is captured in the output register, from which out_bus offers it to the receiver.
//   Throughput is one beat per cycle unless out_bus stalls or the RAM clears, set by the
//   single decode stage and the one write and one read port of the display RAM.
//   After rst_n the control state returns to its reset values and the display RAM
//   is swept to zero, one entry per cycle, over all COLUMNS*BANKS entries (504 with the
//   default geometry); in_bus.ready stays low during that sweep.
//   When the receiver stalls, the result is held; if the input register is empty one
//   more sample beat is taken into it, otherwise in_bus.ready drops in the same cycle,
//   and it stays low until out_bus moves.
module serial_graphic_lcd_controller #(
  parameter int COLUMNS = sglcd_pkg::DEF_COLUMNS,
  parameter int BANKS   = sglcd_pkg::DEF_BANKS
) (
  input  logic        clk,
  input  logic        rst_n,
  sglcd_in_if.sink    in_bus,
  sglcd_out_if.source out_bus
);

  localparam int DEPTH  = COLUMNS * BANKS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = sglcd_pkg::COL_W;
  localparam int BW     = sglcd_pkg::BANK_W;
  localparam logic [CW:0] COL_LIM  = (CW+1)'(COLUMNS);
  localparam logic [BW:0] BANK_LIM = (BW+1)'(BANKS);

  sglcd_pkg::item_t             in_item;
  sglcd_pkg::item_t             s1_item_r;
  logic                         s1_v_r;
  sglcd_pkg::res_t              res;
  logic                         in_fire, s1_fire, adv_out, ram_busy;
  logic [ADDR_W-1:0]            view_addr, wr_addr;
  logic [sglcd_pkg::BYTE_W-1:0] rd_data;
  logic                         byp_v_r;
  logic [sglcd_pkg::BYTE_W-1:0] byp_byte_r;
  logic                         view_ok, hit_now;
  logic [sglcd_pkg::BYTE_W-1:0] view_data;

  logic                         out_v_r;
  sglcd_pkg::res_t              out_res_r;
  logic [sglcd_pkg::BYTE_W-1:0] out_view_r;

  // Gather the incoming beat
  assign in_item.rst_n       = in_bus.rst_n;
  assign in_item.cs_n        = in_bus.cs_n;
  assign in_item.dc          = in_bus.dc;
  assign in_item.sdin        = in_bus.sdin;
  assign in_item.sclk        = in_bus.sclk;
  assign in_item.view_column = in_bus.view_column;
  assign in_item.view_bank   = in_bus.view_bank;

  // Handshake: the output register parts the two sides
  assign adv_out      = !out_v_r || out_bus.ready;
  assign s1_fire      = s1_v_r && adv_out;
  assign in_bus.ready = !ram_busy && (!s1_v_r || adv_out);
  assign in_fire      = in_bus.valid && in_bus.ready;

  // Flat RAM addresses: bank-major rows of COLUMNS bytes
  assign view_addr = ADDR_W'(32'(in_bus.view_bank) * 32'(COLUMNS) + 32'(in_bus.view_column));
  assign wr_addr   = ADDR_W'(32'(res.wbank) * 32'(COLUMNS) + 32'(res.wcol));

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (s1_fire) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_item;
    end
  end

  // Catch a write that lands in the same cycle as the view read is issued
  always_ff @(posedge clk) begin
    if (in_fire) begin
      byp_v_r    <= s1_fire && res.wr && (wr_addr == view_addr);
      byp_byte_r <= res.wbyte;
    end
  end

  sglcd_core #(
    .COLUMNS (COLUMNS),
    .BANKS   (BANKS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (s1_fire),
    .item  (s1_item_r),
    .res   (res)
  );

  sglcd_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (s1_fire && res.wr),
    .wr_addr (wr_addr),
    .wr_data (res.wbyte),
    .rd_en   (in_fire),
    .rd_addr (view_addr),
    .rd_data (rd_data),
    .busy    (ram_busy)
  );

  // View byte after this beat's write
  assign view_ok = ({1'b0, s1_item_r.view_column} < COL_LIM) &&
                   ({1'b0, s1_item_r.view_bank} < BANK_LIM);
  assign hit_now = res.wr && (res.wcol == s1_item_r.view_column) &&
                   (res.wbank == s1_item_r.view_bank);

  always_comb begin
    if (!view_ok) begin
      view_data = '0;
    end else if (hit_now) begin
      view_data = res.wbyte;
    end else if (byp_v_r) begin
      view_data = byp_byte_r;
    end else begin
      view_data = rd_data;
    end
  end

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv_out) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r  <= res;
      out_view_r <= view_data;
    end
  end

  assign out_bus.valid               = out_v_r;
  assign out_bus.ram_write           = out_res_r.wr;
  assign out_bus.write_column        = out_res_r.wcol;
  assign out_bus.write_bank          = out_res_r.wbank;
  assign out_bus.write_byte          = out_res_r.wbyte;
  assign out_bus.view_data           = out_view_r;
  assign out_bus.power_down          = out_res_r.pd;
  assign out_bus.vertical_addressing = out_res_r.vert;
  assign out_bus.extended_set        = out_res_r.ext;
  assign out_bus.display_d           = out_res_r.disp_d;
  assign out_bus.display_e           = out_res_r.disp_e;

endmodule
